[hw/rtl/sbs_pkg.sv]
// Shared types, constants and codes for the servo bank smoother.
package sbs_pkg;

	// Bank geometry
	localparam int LEGS         = 4;
	localparam int JOINTS       = 3;
	localparam int PWM_CHANNELS = 16;
	localparam int NSERVO       = LEGS * JOINTS;

	localparam int IDX_W  = $clog2(NSERVO + 1);
	localparam int JIDX_W = (NSERVO > 1) ? $clog2(NSERVO) : 1;
	localparam int LEG_W  = (LEGS > 1) ? $clog2(LEGS) : 1;
	localparam int J_W    = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	// Field widths
	localparam int ANG_W = 16;
	localparam int PW_W  = 12;
	localparam int CH_W  = 4;
	localparam int CFG_W = 16;
	localparam int CIX_W = 3;

	// Datapath widths
	localparam int MUL_W  = 18;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DEN_W  = 17;
	localparam int BASE_W = 28;
	localparam int TOT_W  = 29;
	localparam int CNT_W  = $clog2(PW_W);

	// Smoothing factor limits, Q1.15
	localparam logic [15:0] ALPHA_ONE = 16'd32768;
	localparam logic [15:0] ALPHA_MIN = 16'd1638;
	localparam logic [15:0] ALPHA_RST = 16'd3277;

	// Register reset values
	localparam logic signed [ANG_W-1:0] JMIN_RST  = -16'sd6431;
	localparam logic signed [ANG_W-1:0] JMAX_RST  = 16'sd6431;
	localparam logic signed [ANG_W-1:0] SMAX_RST  = 16'sd12296;
	localparam logic [PW_W-1:0]         PMIN_RST  = 12'd110;
	localparam logic [PW_W-1:0]         PMAX_RST  = 12'd510;
	localparam logic signed [ANG_W-1:0] START_RST = -16'sd6144;
	// Pulse of the start angle under the reset mapping
	localparam logic [PW_W-1:0]         LAST_RST  = 12'd118;

	localparam logic [CH_W-1:0] SENSOR_CH = 4'd15;

	typedef enum logic [1:0] {
		FN_LEG    = 2'd0,
		FN_SENSOR = 2'd1,
		FN_TICK   = 2'd2,
		FN_CAL    = 2'd3
	} func_t;

	typedef enum logic [CIX_W-1:0] {
		CFG_JMIN  = 3'd0,
		CFG_JMAX  = 3'd1,
		CFG_SMAX  = 3'd2,
		CFG_PMIN  = 3'd3,
		CFG_PMAX  = 3'd4,
		CFG_START = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SMOOTH,
		S_POSE,
		S_CLAMP,
		S_NUM,
		S_SUM,
		S_DIV,
		S_EMIT,
		S_FLUSH
	} state_t;

	typedef struct packed {
		func_t                    func;
		logic [1:0]               leg_select;
		logic signed [ANG_W-1:0]  hip_angle;
		logic signed [ANG_W-1:0]  knee_angle;
		logic signed [ANG_W-1:0]  foot_angle;
		logic [15:0]              smoothing;
		logic signed [ANG_W-1:0]  sensor_angle;
		logic [CH_W-1:0]          cal_channel;
		logic signed [15:0]       cal_pulse;
	} cmd_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic [PW_W-1:0] pulse;
		logic            last;
	} wr_t;

	// Sequencer to output stage
	typedef struct packed {
		logic            emit;
		logic            flush;
		logic [CH_W-1:0] channel;
		logic [PW_W-1:0] pulse;
	} push_t;

	// Output stage status back to the sequencer
	typedef struct packed {
		logic ready;
		logic pending;
	} ostat_t;

endpackage

[hw/rtl/servo_bank_smoother.sv]
// Top level: servo state, shared multiplier and the tick sequencer.
//
// Leg commands, sensor targets and register writes update the state directly.
// A calibration write is pushed to the output stage and then flushed. A tick
// walks the 12 joints and then the sensor through one shared 18x18 multiplier
// (used for the smoothing step, the range base and the slope term) and a
// restoring divider that yields one quotient bit per cycle. A servo whose mapping
// range is empty skips the multiply and divide, and a stall on the result side
// holds the tick. The block takes no new command until a tick or calibration write
// is fully handed to the output. Each tick emits only the channels whose pulse
// changed, in the order front-left, front-right, back-right, back-left, sensor,
// with last set on the final write of the command. Writes to the start angle
// index are ignored; the start pose is fixed at its reset value.
module servo_bank_smoother (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  sbs_pkg::cmd_t                 cmd,
	output logic                          wr_valid,
	input  logic                          wr_stall,
	output sbs_pkg::wr_t                  wr,
	input  logic                          cfg_we,
	input  logic [sbs_pkg::CIX_W-1:0]     cfg_index,
	input  logic [sbs_pkg::CFG_W-1:0]     cfg_data
);

	localparam int NS  = sbs_pkg::NSERVO;
	localparam int AW  = sbs_pkg::ANG_W;
	localparam int PW  = sbs_pkg::PW_W;

	sbs_pkg::state_t state_q, state_d;

	// Configuration
	logic signed [AW-1:0] jmin_q, jmax_q, smax_q;
	logic [PW-1:0]        pmin_q, pmax_q;

	// Servo state
	logic signed [AW-1:0] pose_q   [NS];
	logic signed [AW-1:0] target_q [NS];
	logic signed [AW-1:0] sensor_target_q;
	logic [15:0]          shared_alpha_q;
	logic [PW-1:0]        last_q   [NS+1];
	logic                 lval_q   [NS+1];

	// Sequencer counters
	logic [sbs_pkg::IDX_W-1:0] idx_q;
	logic [sbs_pkg::J_W-1:0]   jnt_q;
	logic [sbs_pkg::LEG_W-1:0] cleg_q;
	logic [15:0]               alpha_q;

	// Datapath registers
	logic signed [sbs_pkg::PROD_W-1:0] prod_q;
	logic signed [AW-1:0]              angle_q, lo_q, hi_q;
	logic [sbs_pkg::DEN_W-1:0]         den_q, off_q;
	logic [sbs_pkg::BASE_W-1:0]        base_q;
	logic [PW-1:0]                     pulse_q;

	logic                              cmd_acc;
	logic                              is_sensor;
	logic [sbs_pkg::JIDX_W-1:0]        jidx;
	logic signed [AW:0]                delta;
	logic signed [AW-1:0]              new_pose;
	logic signed [AW-1:0]              a_cl;
	logic                              empty_rng;
	logic signed [12:0]                pw_diff;
	logic signed [sbs_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic signed [30:0]                tot;
	logic [sbs_pkg::TOT_W-1:0]         dividend;
	logic [15:0]                       alpha_cl;
	logic [PW-1:0]                     cal_sat;
	logic [sbs_pkg::CH_W-1:0]          cur_ch;
	logic                              changed;
	logic                              proceed;
	logic                              div_start, div_done;
	logic [PW-1:0]                     div_quot;
	sbs_pkg::push_t                    push;
	sbs_pkg::ostat_t                   ostat;

	// Datapath combinational terms
	always_comb begin
		is_sensor = (idx_q == sbs_pkg::IDX_W'(NS));
		jidx      = is_sensor ? '0 : sbs_pkg::JIDX_W'(idx_q);
		delta     = {target_q[jidx][AW-1], target_q[jidx]} - {pose_q[jidx][AW-1], pose_q[jidx]};
		new_pose  = pose_q[jidx] + prod_q[30:15];
		empty_rng = (hi_q <= lo_q);
		if (angle_q < lo_q) begin
			a_cl = lo_q;
		end else if (angle_q > hi_q) begin
			a_cl = hi_q;
		end else begin
			a_cl = angle_q;
		end
		pw_diff  = $signed({1'b0, pmax_q}) - $signed({1'b0, pmin_q});
		tot      = $signed({3'b000, base_q}) + prod_q[30:0];
		dividend = tot[30] ? '0 : tot[sbs_pkg::TOT_W-1:0];
		if (shared_alpha_q > sbs_pkg::ALPHA_ONE) begin
			alpha_cl = sbs_pkg::ALPHA_ONE;
		end else if (shared_alpha_q <= sbs_pkg::ALPHA_MIN) begin
			alpha_cl = sbs_pkg::ALPHA_MIN;
		end else begin
			alpha_cl = shared_alpha_q;
		end
		if (cmd.cal_pulse < 0) begin
			cal_sat = '0;
		end else if (cmd.cal_pulse > 16'sd4095) begin
			cal_sat = '1;
		end else begin
			cal_sat = cmd.cal_pulse[PW-1:0];
		end
		cur_ch  = is_sensor ? sbs_pkg::SENSOR_CH
		        : sbs_pkg::CH_W'(int'(cleg_q) * sbs_pkg::JOINTS + int'(jnt_q));
		changed = !lval_q[idx_q] || (last_q[idx_q] != pulse_q);
		proceed = !changed || ostat.ready;
	end

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			sbs_pkg::S_SMOOTH: begin
				mul_a = {delta[AW], delta};
				mul_b = {2'b00, alpha_q};
			end
			sbs_pkg::S_CLAMP: begin
				mul_a = {6'd0, pmin_q};
				mul_b = {1'b0, sbs_pkg::DEN_W'({hi_q[AW-1], hi_q} - {lo_q[AW-1], lo_q})};
			end
			sbs_pkg::S_NUM: begin
				mul_a = {1'b0, off_q};
				mul_b = {{5{pw_diff[12]}}, pw_diff};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sbs_pkg::S_IDLE: begin
				if (cmd_acc && cmd.func == sbs_pkg::FN_TICK) begin
					state_d = sbs_pkg::S_SMOOTH;
				end else if (cmd_acc && cmd.func == sbs_pkg::FN_CAL) begin
					state_d = sbs_pkg::S_FLUSH;
				end
			end
			sbs_pkg::S_SMOOTH: state_d = is_sensor ? sbs_pkg::S_CLAMP : sbs_pkg::S_POSE;
			sbs_pkg::S_POSE:   state_d = sbs_pkg::S_CLAMP;
			sbs_pkg::S_CLAMP:  state_d = empty_rng ? sbs_pkg::S_EMIT : sbs_pkg::S_NUM;
			sbs_pkg::S_NUM:    state_d = sbs_pkg::S_SUM;
			sbs_pkg::S_SUM:    state_d = sbs_pkg::S_DIV;
			sbs_pkg::S_DIV: begin
				if (div_done) begin
					state_d = sbs_pkg::S_EMIT;
				end
			end
			sbs_pkg::S_EMIT: begin
				if (proceed) begin
					state_d = is_sensor ? sbs_pkg::S_FLUSH : sbs_pkg::S_SMOOTH;
				end
			end
			sbs_pkg::S_FLUSH: begin
				if (ostat.ready) begin
					state_d = sbs_pkg::S_IDLE;
				end
			end
			default: state_d = sbs_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		cmd_stall    = (state_q != sbs_pkg::S_IDLE);
		cmd_acc      = cmd_valid && (state_q == sbs_pkg::S_IDLE);
		div_start    = (state_q == sbs_pkg::S_SUM);
		push.emit    = 1'b0;
		push.flush   = 1'b0;
		push.channel = cur_ch;
		push.pulse   = pulse_q;
		case (state_q)
			sbs_pkg::S_IDLE: begin
				push.emit    = cmd_acc && (cmd.func == sbs_pkg::FN_CAL);
				push.channel = cmd.cal_channel;
				push.pulse   = cal_sat;
			end
			sbs_pkg::S_EMIT:  push.emit  = changed;
			sbs_pkg::S_FLUSH: push.flush = 1'b1;
			default: begin
				push.emit  = 1'b0;
				push.flush = 1'b0;
			end
		endcase
	end

	// Control state, configuration and servo state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= sbs_pkg::S_IDLE;
			jmin_q          <= sbs_pkg::JMIN_RST;
			jmax_q          <= sbs_pkg::JMAX_RST;
			smax_q          <= sbs_pkg::SMAX_RST;
			pmin_q          <= sbs_pkg::PMIN_RST;
			pmax_q          <= sbs_pkg::PMAX_RST;
			sensor_target_q <= '0;
			shared_alpha_q  <= sbs_pkg::ALPHA_RST;
			idx_q           <= '0;
			jnt_q           <= '0;
			cleg_q          <= '0;
			alpha_q         <= sbs_pkg::ALPHA_RST;
			for (int k = 0; k < NS; k++) begin
				pose_q[k]   <= sbs_pkg::START_RST;
				target_q[k] <= sbs_pkg::START_RST;
				last_q[k]   <= sbs_pkg::LAST_RST;
				lval_q[k]   <= 1'b1;
			end
			last_q[NS] <= '0;
			lval_q[NS] <= 1'b0;
		end else begin
			state_q <= state_d;

			// Register writes
			if (cfg_we) begin
				case (sbs_pkg::cfg_idx_t'(cfg_index))
					sbs_pkg::CFG_JMIN: jmin_q <= cfg_data;
					sbs_pkg::CFG_JMAX: jmax_q <= cfg_data;
					sbs_pkg::CFG_SMAX: smax_q <= cfg_data;
					sbs_pkg::CFG_PMIN: pmin_q <= cfg_data[PW-1:0];
					sbs_pkg::CFG_PMAX: pmax_q <= cfg_data[PW-1:0];
					default: begin
						jmin_q <= jmin_q;
					end
				endcase
			end

			// Commands taken in idle
			if (cmd_acc) begin
				case (cmd.func)
					sbs_pkg::FN_LEG: begin
						for (int l = 0; l < sbs_pkg::LEGS; l++) begin
							if (int'(cmd.leg_select) == l) begin
								for (int j = 0; j < sbs_pkg::JOINTS; j++) begin
									target_q[l*sbs_pkg::JOINTS+j] <= (j == 0) ? cmd.hip_angle
										: (j == 1) ? cmd.knee_angle : cmd.foot_angle;
									if (cmd.smoothing == '0) begin
										pose_q[l*sbs_pkg::JOINTS+j] <= (j == 0) ? cmd.hip_angle
											: (j == 1) ? cmd.knee_angle : cmd.foot_angle;
									end
								end
								shared_alpha_q <= cmd.smoothing;
							end
						end
					end
					sbs_pkg::FN_SENSOR: sensor_target_q <= cmd.sensor_angle;
					sbs_pkg::FN_TICK: begin
						idx_q   <= '0;
						jnt_q   <= '0;
						cleg_q  <= sbs_pkg::LEG_W'(2 % sbs_pkg::LEGS);
						alpha_q <= alpha_cl;
					end
					default: begin
						idx_q <= idx_q;
					end
				endcase
			end

			// Commit the smoothed pose
			if (state_q == sbs_pkg::S_POSE) begin
				pose_q[jidx] <= new_pose;
			end

			// Record the write and advance to the next servo
			if (state_q == sbs_pkg::S_EMIT && proceed) begin
				if (changed) begin
					last_q[idx_q] <= pulse_q;
					lval_q[idx_q] <= 1'b1;
				end
				if (!is_sensor) begin
					idx_q <= idx_q + 1'b1;
					if (jnt_q == sbs_pkg::J_W'(sbs_pkg::JOINTS - 1)) begin
						jnt_q  <= '0;
						cleg_q <= (cleg_q == sbs_pkg::LEG_W'(sbs_pkg::LEGS - 1)) ? '0
						        : cleg_q + 1'b1;
					end else begin
						jnt_q <= jnt_q + 1'b1;
					end
				end
			end
		end
	end

	// Datapath payload registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			sbs_pkg::S_SMOOTH: begin
				if (is_sensor) begin
					angle_q <= sensor_target_q;
					lo_q    <= '0;
					hi_q    <= smax_q;
				end
			end
			sbs_pkg::S_POSE: begin
				angle_q <= new_pose;
				lo_q    <= jmin_q;
				hi_q    <= jmax_q;
			end
			sbs_pkg::S_CLAMP: begin
				if (empty_rng) begin
					pulse_q <= pmin_q;
				end else begin
					den_q <= sbs_pkg::DEN_W'({hi_q[AW-1], hi_q} - {lo_q[AW-1], lo_q});
					off_q <= sbs_pkg::DEN_W'({a_cl[AW-1], a_cl} - {lo_q[AW-1], lo_q});
				end
			end
			sbs_pkg::S_NUM: base_q <= prod_q[sbs_pkg::BASE_W-1:0];
			sbs_pkg::S_DIV: begin
				if (div_done) begin
					pulse_q <= div_quot;
				end
			end
			default: begin
				base_q <= base_q;
			end
		endcase
	end

	sbs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (den_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	sbs_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.stat     (ostat),
		.wr_valid (wr_valid),
		.wr_stall (wr_stall),
		.wr       (wr)
	);

`ifndef SYNTH
	// Nothing may be held back once the block is idle again
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sbs_pkg::S_IDLE |-> !ostat.pending)
		else $error("held write left over in idle");

	// The divider only finishes while the sequencer waits for it
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == sbs_pkg::S_DIV)
		else $error("divider finished outside divide state");

	// The servo index never runs past the sensor slot
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= sbs_pkg::IDX_W'(NS))
		else $error("servo index out of range");

	// A blocked changed write keeps the sequencer on the same servo
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbs_pkg::S_EMIT && changed && !ostat.ready)
		|=> (state_q == sbs_pkg::S_EMIT && $stable(idx_q)))
		else $error("write dropped while output was blocked");
`endif

endmodule

[hw/rtl/sbs_div.sv]
// Restoring divider, one quotient bit per cycle, 12-bit quotient.
module sbs_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [sbs_pkg::TOT_W-1:0]      dividend,
	input  logic [sbs_pkg::DEN_W-1:0]      divisor,
	output logic                           done,
	output logic [sbs_pkg::PW_W-1:0]       quot
);

	logic                          busy_q;
	logic [sbs_pkg::CNT_W-1:0]     cnt_q;
	logic [sbs_pkg::DEN_W-1:0]     rem_q;
	logic [sbs_pkg::DEN_W-1:0]     den_q;
	logic [sbs_pkg::PW_W-1:0]      low_q;
	logic [sbs_pkg::PW_W-1:0]      q_q;
	logic [sbs_pkg::DEN_W:0]       trial;
	logic [sbs_pkg::DEN_W:0]       diff;
	logic                          qbit;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		trial = {rem_q, low_q[sbs_pkg::PW_W-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	assign done = busy_q && (cnt_q == '0);
	assign quot = {q_q[sbs_pkg::PW_W-2:0], qbit};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= sbs_pkg::CNT_W'(sbs_pkg::PW_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Partial remainder and quotient; the top bits always sit below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[sbs_pkg::TOT_W-1:sbs_pkg::PW_W];
			low_q <= dividend[sbs_pkg::PW_W-1:0];
			den_q <= divisor;
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[sbs_pkg::DEN_W-1:0] : trial[sbs_pkg::DEN_W-1:0];
			low_q <= {low_q[sbs_pkg::PW_W-2:0], 1'b0};
			q_q   <= {q_q[sbs_pkg::PW_W-2:0], qbit};
		end
	end

endmodule

[hw/rtl/sbs_out.sv]
// Output stage: one held write plus the output register, marks the final write.
module sbs_out (
	input  logic                clk,
	input  logic                arst_n,
	input  sbs_pkg::push_t      push,
	output sbs_pkg::ostat_t     stat,
	output logic                wr_valid,
	input  logic                wr_stall,
	output sbs_pkg::wr_t        wr
);

	logic                        pend_valid_q;
	logic [sbs_pkg::CH_W-1:0]    pend_ch_q;
	logic [sbs_pkg::PW_W-1:0]    pend_pw_q;
	logic                        out_valid_q;
	sbs_pkg::wr_t                out_q;
	logic                        slot_free;
	logic                        move;

	// A held write leaves only when a newer one arrives or the item ends
	assign slot_free  = !out_valid_q || !wr_stall;
	assign stat.ready = !pend_valid_q || slot_free;
	assign stat.pending = pend_valid_q;
	assign move = (push.emit || push.flush) && pend_valid_q && slot_free;

	assign wr_valid = out_valid_q;
	assign wr       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !wr_stall) begin
				out_valid_q <= 1'b0;
			end
			if (push.emit && stat.ready) begin
				pend_valid_q <= 1'b1;
			end else if (push.flush && stat.ready) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Payload: hold new write, move held one out with its last flag
	always_ff @(posedge clk) begin
		if (move) begin
			out_q.channel <= pend_ch_q;
			out_q.pulse   <= pend_pw_q;
			out_q.last    <= push.flush;
		end
		if (push.emit && stat.ready) begin
			pend_ch_q <= push.channel;
			pend_pw_q <= push.pulse;
		end
	end

endmodule
